### src/rms_onset_detector_with_cooldown_defines.svh
// Assertion macros shared by the RMS onset detector RTL.
`ifndef RMS_ONSET_DETECTOR_WITH_COOLDOWN_DEFINES_SVH
`define RMS_ONSET_DETECTOR_WITH_COOLDOWN_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RODC_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RODC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

### src/rodc_pkg.sv
// Shared types and constants of the RMS onset detector.
`timescale 1ns / 1ps

package rodc_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int RMS_W       = 16;
   localparam int THR_W       = 16;
   localparam int COOL_W      = 16;
   localparam int SQ_W        = 31;           // square of a Q1.15 sample, at most 2^30
   localparam int MEAN_W      = 32;           // mean square as fed to the root unit
   localparam int SQ_REM_W    = RMS_W + 2;    // root remainder
   localparam int SQRT_STEPS  = MEAN_W / 2;
   localparam int RMS_MAX     = 32768;

   // Stream payloads
   localparam int REQ_TDATA_W = SAMPLE_W + TIME_W;
   localparam int RSP_TDATA_W = RMS_W + TIME_W;

   // Register port
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic             DETECT_ENABLE_RST  = 1'b1;
   localparam logic [THR_W-1:0] RISE_THRESHOLD_RST = 16'd3277;
   localparam logic [COOL_W-1:0] COOLDOWN_MS_RST   = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DETECT_ENABLE  = 2'd0,
      CSR_RISE_THRESHOLD = 2'd1,
      CSR_COOLDOWN_MS    = 2'd2
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic accumulate;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

### src/rms_onset_detector_with_cooldown.sv
// Top level of the RMS onset detector: register file, controller and datapath.
//
//   Channel | Ports                         | Carries
//   --------+-------------------------------+----------------------------------------
//   req     | req_tvalid/tready/tdata/tlast | sample, last_in_block, now_ms
//   rsp     | rsp_tvalid/tready/tdata/tuser | block_rms, onset, onset_time_ms
//   csr     | csr_valid/ready/index/data    | detect_enable, rise_threshold, cooldown_ms
//
// A request that does not end a block is accepted while the controller is idle. The
// last request of a block, with detection enabled, starts the computation: load,
// restoring divider, root load, square root unit and decision steps, in that order.
// Synchronous active-high reset clears sums, previous RMS and last onset time.
// A result waits in the output register while the next block is being accumulated;
// the next block's computation waits to finish only if that result is still not taken.
`timescale 1ns / 1ps
`include "rms_onset_detector_with_cooldown_defines.svh"

module rms_onset_detector_with_cooldown #(
   parameter int BLOCK_MAX = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [15:0] sample, [47:16] now_ms
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rodc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tlast,
   // response: [15:0] block_rms, [47:16] onset_time_ms
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rodc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // response: [0] onset
   output logic                               rsp_tuser,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rodc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rodc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rodc_pkg::*;

   localparam int SUM_W = SQ_W - 1 + $clog2(BLOCK_MAX + 1);

   // Configuration registers
   logic               detect_enable_ff;
   logic [THR_W-1:0]   rise_threshold_ff;
   logic [COOL_W-1:0]  cooldown_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_enable_ff  <= DETECT_ENABLE_RST;
         rise_threshold_ff <= RISE_THRESHOLD_RST;
         cooldown_ms_ff    <= COOLDOWN_MS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DETECT_ENABLE:  detect_enable_ff  <= csr_data[0];
            CSR_RISE_THRESHOLD: rise_threshold_ff <= csr_data[THR_W-1:0];
            CSR_COOLDOWN_MS:    cooldown_ms_ff    <= csr_data[COOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Controller and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic [RMS_W-1:0]  block_rms;
   logic [TIME_W-1:0] onset_time_ms;

   rodc_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tlast     (req_tlast),
      .detect_enable (detect_enable_ff),
      .status        (dp_status),
      .req_tready    (req_tready),
      .cmd           (dp_cmd)
   );

   rodc_datapath #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .sample         ($signed(req_tdata[SAMPLE_W-1:0])),
      .now_ms         (req_tdata[SAMPLE_W +: TIME_W]),
      .rise_threshold (rise_threshold_ff),
      .cooldown_ms    (cooldown_ms_ff),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .block_rms      (block_rms),
      .onset          (rsp_tuser),
      .onset_time_ms  (onset_time_ms)
   );

   assign rsp_tdata = {onset_time_ms, block_rms};

   // Checks
   `RODC_ASSERT_NEXT(a_block_end_stalls, clock, reset, req_tvalid && req_tready && req_tlast && detect_enable_ff, !req_tready, "block end did not start computation")
   `RODC_ASSERT_NOW(a_rsp_after_compute, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "response appeared without a computation phase")
   `RODC_ASSERT_NOW(a_rms_range, clock, reset, rsp_tvalid, {1'b0, rsp_tdata[RMS_W-1:0]} <= (RMS_W + 1)'(RMS_MAX), "block RMS above full scale")
   `RODC_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0(dp_cmd), "controller issued overlapping commands")

endmodule

### src/rodc_ctrl.sv
// Controller FSM: sequences accumulation, division, square root and result load.
`timescale 1ns / 1ps

module rodc_ctrl #(
   parameter int SUM_W = 41
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   input  logic                   detect_enable,
   input  rodc_pkg::dp_status_type status,
   output logic                   req_tready,
   output rodc_pkg::dp_cmd_type   cmd
);
   import rodc_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_SQ_LOAD,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && detect_enable) begin
               cmd.accumulate = 1'b1;
               if (req_tlast) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = STEP_W'(SUM_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SQ_LOAD;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SQ_LOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = STEP_W'(SQRT_STEPS - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### src/rodc_datapath.sv
// Datapath: square accumulator, restoring divider, bitwise root, onset decision.
`timescale 1ns / 1ps

module rodc_datapath #(
   parameter int BLOCK_MAX = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rodc_pkg::dp_cmd_type               cmd,
   output rodc_pkg::dp_status_type            status,
   input  logic signed [rodc_pkg::SAMPLE_W-1:0] sample,
   input  logic [rodc_pkg::TIME_W-1:0]        now_ms,
   input  logic [rodc_pkg::THR_W-1:0]         rise_threshold,
   input  logic [rodc_pkg::COOL_W-1:0]        cooldown_ms,
   input  logic                               rsp_tready,
   output logic                               rsp_valid,
   output logic [rodc_pkg::RMS_W-1:0]         block_rms,
   output logic                               onset,
   output logic [rodc_pkg::TIME_W-1:0]        onset_time_ms
);
   import rodc_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_MAX + 1);
   localparam int SUM_W = SQ_W - 1 + CNT_W;

   // Accumulator
   logic signed [2*SAMPLE_W-1:0] product;
   logic [SQ_W-1:0]              square;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [TIME_W-1:0]            now_ff;

   assign product = sample * sample;
   assign square  = product[SQ_W-1:0];

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.accumulate) begin
         // saturate: samples past the block limit are dropped
         if (count_ff < CNT_W'(BLOCK_MAX)) begin
            sum_in   = sum_ff + SUM_W'(square);
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.div_load) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   // Restoring divider, one quotient bit per cycle
   logic [SUM_W-1:0] div_quot_ff;
   logic [CNT_W-1:0] div_rem_ff;
   logic [CNT_W-1:0] div_den_ff;
   logic [CNT_W:0]   div_shift;
   logic [CNT_W:0]   div_diff;
   logic             div_ge;

   assign div_shift = {div_rem_ff, div_quot_ff[SUM_W-1]};
   assign div_ge    = div_shift >= {1'b0, div_den_ff};
   assign div_diff  = div_shift - {1'b0, div_den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_quot_ff <= sum_ff;
         div_rem_ff  <= '0;
         div_den_ff  <= count_ff;
      end else if (cmd.div_step) begin
         div_rem_ff  <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
         div_quot_ff <= {div_quot_ff[SUM_W-2:0], div_ge};
      end
   end

   // Digit-by-digit square root, two radicand bits per cycle
   logic [MEAN_W-1:0]   sq_val_ff;
   logic [SQ_REM_W-1:0] sq_rem_ff;
   logic [RMS_W-1:0]    sq_root_ff;
   logic [SQ_REM_W+1:0] sq_cur;
   logic [SQ_REM_W+1:0] sq_trial;
   logic [SQ_REM_W+1:0] sq_diff;
   logic                sq_ge;

   assign sq_cur   = {sq_rem_ff, sq_val_ff[MEAN_W-1 -: 2]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge    = sq_cur >= sq_trial;
   assign sq_diff  = sq_cur - sq_trial;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         // mean square never exceeds 2^30
         sq_val_ff  <= {1'b0, div_quot_ff[MEAN_W-2:0]};
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_val_ff  <= {sq_val_ff[MEAN_W-3:0], 2'b00};
         sq_rem_ff  <= sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_cur[SQ_REM_W-1:0];
         sq_root_ff <= {sq_root_ff[RMS_W-2:0], sq_ge};
      end
   end

   // Onset decision: strict rise test, cooldown in 33 bits without wrap
   logic [RMS_W-1:0]         prev_rms_ff;
   logic [TIME_W-1:0]        last_onset_ff;
   logic signed [RMS_W:0]    rise;
   logic                     rise_ok;
   logic [TIME_W:0]          cool_end;
   logic                     time_ok;
   logic                     onset_now;

   assign rise      = $signed({1'b0, sq_root_ff}) - $signed({1'b0, prev_rms_ff});
   assign rise_ok   = rise > $signed({1'b0, rise_threshold});
   assign cool_end  = (TIME_W + 1)'(last_onset_ff) + (TIME_W + 1)'(cooldown_ms);
   assign time_ok   = (TIME_W + 1)'(now_ff) > cool_end;
   assign onset_now = rise_ok && time_ok;

   // Output register
   logic                rsp_valid_ff;
   logic [RMS_W-1:0]    rms_out_ff;
   logic                onset_out_ff;
   logic [TIME_W-1:0]   time_out_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         count_ff      <= '0;
         prev_rms_ff   <= '0;
         last_onset_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (cmd.finish) begin
            prev_rms_ff  <= sq_root_ff;
            rsp_valid_ff <= 1'b1;
            if (onset_now) begin
               last_onset_ff <= now_ff;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         now_ff <= now_ms;
      end
      if (cmd.finish) begin
         rms_out_ff   <= sq_root_ff;
         onset_out_ff <= onset_now;
         time_out_ff  <= onset_now ? now_ff : last_onset_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign block_rms     = rms_out_ff;
   assign onset         = onset_out_ff;
   assign onset_time_ms = time_out_ff;

endmodule
